// ===== sv/wfmc_pkg.sv =====
// wfmc_pkg: shared types and constants for the wall follow mode controller.
// No dependencies.
`timescale 1ns / 1ps
package wfmc_pkg;
   localparam logic [2:0] MODE_COMPLETE = 3'd0;
   localparam logic [2:0] MODE_FOLLOW   = 3'd1;
   localparam logic [2:0] MODE_OUTSIDE  = 3'd2;
   localparam logic [2:0] MODE_INSIDE   = 3'd3;
   localparam logic [2:0] MODE_IDLE     = 3'd4;

   localparam logic [2:0] CSR_FOLLOW_DISTANCE   = 3'd0;
   localparam logic [2:0] CSR_FOLLOW_MARGIN     = 3'd1;
   localparam logic [2:0] CSR_STOP_DISTANCE     = 3'd2;
   localparam logic [2:0] CSR_CHECK_DISTANCE    = 3'd3;
   localparam logic [2:0] CSR_GAIN_PROP_WALL    = 3'd4;
   localparam logic [2:0] CSR_GAIN_INT_WALL     = 3'd5;
   localparam logic [2:0] CSR_GAIN_DERIV_WALL   = 3'd6;
   localparam logic [2:0] CSR_GAIN_PROP_HEADING = 3'd7;

   localparam logic signed [15:0] Q_FWD       = 16'sd287;
   localparam logic signed [15:0] Q_SWEEP_LIN = 16'sd410;
   localparam logic signed [15:0] Q_SLOW      = 16'sd205;
   localparam logic signed [15:0] Q_TURN_NEG  = -16'sd4096;
   localparam logic signed [15:0] Q_LOOP_TURN = -16'sd2048;
   localparam logic signed [17:0] Q_INT_MAX   = 18'sd6144;
   localparam logic signed [15:0] Q_U_MAX     = 16'sd410;
   localparam logic [16:0] Q_HEAD_STOP        = 17'd410;
   localparam logic [16:0] Q_STOP_EXTRA       = 17'd410;
   localparam logic [16:0] Q_RADIUS_MAX       = 17'd1638;
   localparam logic [23:0] Q_SWEEP_DIVIDEND   = 24'd2351104; // 574 << 12

   // Shared multiplier operation.
   typedef struct packed {
      logic signed [18:0] a;
      logic signed [16:0] b;
   } mul_op_type;
endpackage

// ===== sv/wfmc_mul.sv =====
// wfmc_mul: shared signed 19x17 multiplier with registered product.
// Depends on wfmc_pkg.
`timescale 1ns / 1ps
module wfmc_mul (
   input  logic                  clock,
   input  wfmc_pkg::mul_op_type  op,
   output logic signed [35:0]    prod
);
   logic signed [35:0] prod_ff;
   always_ff @(posedge clock) begin
      prod_ff <= 36'(op.a * op.b);
   end
   assign prod = prod_ff;
endmodule

// ===== sv/wfmc_div.sv =====
// wfmc_div: restoring divider, one quotient bit per cycle (24 / 16 bit).
// Depends on nothing but the timescale.
`timescale 1ns / 1ps
module wfmc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [23:0] quotient
);
   logic [23:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[15:0], quo_ff[23]};
      if (start) begin
         quo_in = dividend; rem_in = '0; cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[22:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in;
   end
   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== sv/wall_follow_mode_controller_core.sv =====
// wall_follow_mode_controller_core: top level of the wall follow mode controller.
// Depends on wfmc_pkg, wfmc_mul and wfmc_div.
`timescale 1ns / 1ps
// Path from the accepting edge to rsp_valid: mode decisions, exits, inside, idle and
// zero-radius sweep go from evaluation to output; heading hold via head, wait, hold;
// PID via P, I and D (three passes through the one shared multiplier), accumulate, hold;
// the outside sweep waits for the bit-serial divider (one quotient bit per cycle). One
// word in flight; the next word is taken the cycle after the result is registered.
// Reset (synchronous, active high) restores CSR defaults, mode inside, zero state.
module wall_follow_mode_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_ahead_narrow_min,
   input  logic [15:0]        req_ahead_wide_min,
   input  logic [15:0]        req_left_wide_min,
   input  logic [15:0]        req_left_mid_min,
   input  logic [15:0]        req_left_narrow_min,
   input  logic [15:0]        req_left_broad_min,
   input  logic [15:0]        req_front_left_min,
   input  logic [15:0]        req_front_left_median,
   input  logic signed [15:0] req_wall_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_linear_velocity,
   output logic signed [15:0] rsp_angular_velocity,
   output logic [2:0]         rsp_mode_after,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EVAL  = 4'd1;
   localparam logic [3:0] S_MUL_P = 4'd2;
   localparam logic [3:0] S_MUL_I = 4'd3;
   localparam logic [3:0] S_MUL_D = 4'd4;
   localparam logic [3:0] S_ACC   = 4'd5;
   localparam logic [3:0] S_HEAD  = 4'd6;
   localparam logic [3:0] S_HWAIT = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_DWAIT = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;

   // CSRs
   logic [15:0] fol_d_ff, fol_m_ff, stop_d_ff, chk_d_ff, kp_ff, ki_ff, kd_ff, kh_ff;

   // architectural state
   logic [2:0]         mode_ff, mode_in;
   logic [15:0]        radius_ff, radius_in;
   logic signed [17:0] integ_ff, integ_in;
   logic signed [17:0] last_ff, last_in;

   // captured input word
   logic [15:0] an_ff, aw_ff, lw_ff, lm_ff, ln_ff, lb_ff, fl_ff, fm_ff;
   logic signed [15:0] hd_ff;

   // working registers
   logic signed [17:0] err_ff, err_in;
   logic signed [37:0] acc_ff, acc_in;
   logic signed [15:0] lin_ff, lin_in, ang_ff, ang_in;
   logic               rv_ff, rv_in;
   logic               head_flag_ff, head_flag_in, divw_ff, divw_in;
   logic signed [17:0] last_prev_ff;

   // output word register; frees the sequencer while a result waits
   logic signed [15:0] out_lin_ff, out_lin_in, out_ang_ff, out_ang_in;
   logic [2:0]         out_mode_ff, out_mode_in;

   wfmc_pkg::mul_op_type mop;
   logic signed [35:0]   prod;
   logic                 div_start, div_done;
   logic [23:0]          quo;

   wfmc_mul u_mul (.clock(clock), .op(mop), .prod(prod));
   wfmc_div u_div (.clock(clock), .reset(reset), .start(div_start),
      .dividend(wfmc_pkg::Q_SWEEP_DIVIDEND), .divisor(radius_ff),
      .done(div_done), .quotient(quo));

   // threshold tests on the captured word
   logic fl_gt_chk, lw_le_chk, an_ge_stop, ln_ok, lm_lt_chk, an_near;
   logic fol_exit, out_exit, in_exit;
   always_comb begin
      fl_gt_chk  = 19'(fl_ff) * 19'd5 > 19'(chk_d_ff) * 19'd6;
      lw_le_chk  = lw_ff <= chk_d_ff;
      an_ge_stop = an_ff >= stop_d_ff;
      ln_ok      = {1'b0, ln_ff, 1'b0} <= 18'(fol_d_ff) * 18'd3;
      lm_lt_chk  = lm_ff < chk_d_ff;
      an_near    = 19'(an_ff) * 19'd5 <= 19'(stop_d_ff) * 19'd6;
      fol_exit   = fl_gt_chk || (lb_ff >= chk_d_ff) || (aw_ff <= stop_d_ff);
      out_exit   = (fm_ff < chk_d_ff) || (an_ff < stop_d_ff);
      in_exit    = {1'b0, an_ff} > ({1'b0, stop_d_ff} + wfmc_pkg::Q_STOP_EXTRA);
   end

   // trunc toward zero of x/4096
   function automatic logic signed [25:0] shr12(input logic signed [37:0] p);
      logic [37:0] m;
      logic [37:0] q;
      m = p[37] ? 38'(-p) : 38'(p);
      q = m >> 12;
      return p[37] ? -26'(q) : 26'(q);
   endfunction

   logic signed [17:0] e_cur, isum;
   logic [16:0]        e_abs, h_abs;
   logic signed [16:0] h_neg;
   logic [16:0]        r3;
   logic signed [25:0] sh;
   logic [2:0]         m_eff;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; radius_in = radius_ff;
      integ_in = integ_ff; last_in = last_ff; err_in = err_ff; acc_in = acc_ff;
      lin_in = lin_ff; ang_in = ang_ff; rv_in = rv_ff;
      head_flag_in = head_flag_ff; divw_in = divw_ff;
      out_lin_in = out_lin_ff; out_ang_in = out_ang_ff; out_mode_in = out_mode_ff;
      mop.a = '0; mop.b = '0; div_start = 1'b0;
      e_cur = 18'(signed'({2'b0, lm_ff})) - 18'(signed'({2'b0, fol_d_ff}));
      e_abs = e_cur[17] ? 17'(-e_cur) : 17'(e_cur);
      h_neg = -17'(hd_ff);
      h_abs = h_neg[16] ? 17'(-h_neg) : 17'(h_neg);
      // 1.5 * left_wide_min, 18-bit sum so the large end does not wrap
      r3    = 17'(({2'b0, lw_ff} + {1'b0, lw_ff, 1'b0}) >> 1);
      isum  = 18'(integ_ff + e_cur);
      sh    = shr12(acc_ff);
      m_eff = mode_ff;
      // result word taken by the receiver
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_OUT;
            lin_in = '0; ang_in = '0;
            if (mode_ff == wfmc_pkg::MODE_COMPLETE) begin
               if (fl_gt_chk && lw_le_chk) begin
                  if (out_exit) begin
                     lin_in = wfmc_pkg::Q_SLOW; m_eff = wfmc_pkg::MODE_COMPLETE;
                  end else begin
                     radius_in = (r3 > wfmc_pkg::Q_RADIUS_MAX) ?
                        16'(wfmc_pkg::Q_RADIUS_MAX) : r3[15:0];
                     m_eff = wfmc_pkg::MODE_OUTSIDE;
                  end
               end else if (an_ge_stop && ln_ok) begin
                  if (fol_exit) begin
                     ang_in = wfmc_pkg::Q_LOOP_TURN; m_eff = wfmc_pkg::MODE_COMPLETE;
                  end else m_eff = wfmc_pkg::MODE_FOLLOW;
               end else if (lm_lt_chk && an_near) begin
                  if (in_exit) begin
                     ang_in = wfmc_pkg::Q_LOOP_TURN; m_eff = wfmc_pkg::MODE_COMPLETE;
                  end else m_eff = wfmc_pkg::MODE_INSIDE;
               end else m_eff = wfmc_pkg::MODE_IDLE;
            end
            // a decision that stays complete keeps the command set above
            unique case (m_eff)
               wfmc_pkg::MODE_COMPLETE: mode_in = wfmc_pkg::MODE_COMPLETE;
               wfmc_pkg::MODE_FOLLOW: begin
                  if (fol_exit) mode_in = wfmc_pkg::MODE_COMPLETE;
                  else begin
                     mode_in = wfmc_pkg::MODE_FOLLOW;
                     err_in = e_cur; last_in = e_cur;
                     if (e_abs < {1'b0, fol_m_ff}) state_in = S_HEAD;
                     else begin
                        integ_in = (isum > wfmc_pkg::Q_INT_MAX) ? wfmc_pkg::Q_INT_MAX :
                           (isum < -wfmc_pkg::Q_INT_MAX) ? -wfmc_pkg::Q_INT_MAX : isum;
                        state_in = S_MUL_P;
                     end
                  end
               end
               wfmc_pkg::MODE_OUTSIDE: begin
                  if (out_exit) mode_in = wfmc_pkg::MODE_COMPLETE;
                  else begin
                     mode_in = wfmc_pkg::MODE_OUTSIDE;
                     lin_in = wfmc_pkg::Q_SWEEP_LIN;
                     if (radius_in == 16'd0) ang_in = 16'sd32767;
                     else state_in = S_DIV;
                  end
               end
               wfmc_pkg::MODE_INSIDE: begin
                  if (in_exit) mode_in = wfmc_pkg::MODE_COMPLETE;
                  else begin
                     mode_in = wfmc_pkg::MODE_INSIDE; ang_in = wfmc_pkg::Q_TURN_NEG;
                  end
               end
               // idle and unused codes
               default: begin
                  lin_in = wfmc_pkg::Q_SLOW; mode_in = wfmc_pkg::MODE_COMPLETE;
               end
            endcase
         end
         S_MUL_P: begin
            mop.a = 19'(err_ff); mop.b = 17'(signed'({1'b0, kp_ff}));
            acc_in = '0; state_in = S_MUL_I;
         end
         S_MUL_I: begin
            mop.a = 19'(integ_ff); mop.b = 17'(signed'({1'b0, ki_ff}));
            acc_in = 38'(prod); state_in = S_MUL_D;
         end
         S_MUL_D: begin
            // last_ff already holds e; derivative term uses the previous value
            mop.a = 19'(err_ff) - 19'(last_prev_ff);
            mop.b = 17'(signed'({1'b0, kd_ff}));
            acc_in = acc_ff + 38'(prod); state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + 38'(prod); state_in = S_HWAIT;
         end
         S_HEAD: begin
            mop.a = 19'(h_neg); mop.b = 17'(signed'({1'b0, kh_ff}));
            lin_in = (h_abs > wfmc_pkg::Q_HEAD_STOP) ? 16'sd0 : wfmc_pkg::Q_FWD;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            // heading product ready
            acc_in = 38'(prod); state_in = S_HWAIT;
            err_in = '0;
            head_flag_in = 1'b1;
         end
         S_HWAIT: begin
            if (head_flag_ff) begin
               ang_in = (sh > 26'sd32767) ? 16'sd32767 :
                        (sh < -26'sd32768) ? -16'sd32768 : 16'(sh);
            end else begin
               ang_in = (sh > 26'(wfmc_pkg::Q_U_MAX)) ? wfmc_pkg::Q_U_MAX :
                        (sh < -26'(wfmc_pkg::Q_U_MAX)) ? -wfmc_pkg::Q_U_MAX : 16'(sh);
               lin_in = wfmc_pkg::Q_FWD;
            end
            head_flag_in = 1'b0;
            state_in = S_OUT;
         end
         S_DIV: begin
            div_start = 1'b1; state_in = S_OUT; divw_in = 1'b1;
         end
         S_OUT: begin
            // sweep: latch the saturated quotient first, then publish it as on the other paths
            if (divw_ff) begin
               if (div_done) begin
                  ang_in = (quo > 24'd32767) ? 16'sd32767 : 16'(quo);
                  divw_in = 1'b0;
               end
            end else if (!rv_ff || !rsp_stall) begin
               out_lin_in = lin_ff; out_ang_in = ang_ff; out_mode_in = mode_ff;
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; head_flag_ff <= 1'b0; divw_ff <= 1'b0;
         mode_ff <= wfmc_pkg::MODE_INSIDE; radius_ff <= '0;
         integ_ff <= '0; last_ff <= '0; last_prev_ff <= '0;
         fol_d_ff <= 16'd1147; fol_m_ff <= 16'd287; stop_d_ff <= 16'd1147;
         chk_d_ff <= 16'd1843; kp_ff <= 16'd6144; ki_ff <= 16'd0;
         kd_ff <= 16'd1229; kh_ff <= 16'd6144;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in;
         head_flag_ff <= head_flag_in; divw_ff <= divw_in;
         mode_ff <= mode_in; radius_ff <= radius_in;
         integ_ff <= integ_in; last_ff <= last_in;
         if (state_ff == S_EVAL) last_prev_ff <= last_ff;
         if (csr_write) begin
            unique case (csr_index)
               wfmc_pkg::CSR_FOLLOW_DISTANCE:   fol_d_ff  <= csr_data;
               wfmc_pkg::CSR_FOLLOW_MARGIN:     fol_m_ff  <= csr_data;
               wfmc_pkg::CSR_STOP_DISTANCE:     stop_d_ff <= csr_data;
               wfmc_pkg::CSR_CHECK_DISTANCE:    chk_d_ff  <= csr_data;
               wfmc_pkg::CSR_GAIN_PROP_WALL:    kp_ff     <= csr_data;
               wfmc_pkg::CSR_GAIN_INT_WALL:     ki_ff     <= csr_data;
               wfmc_pkg::CSR_GAIN_DERIV_WALL:   kd_ff     <= csr_data;
               wfmc_pkg::CSR_GAIN_PROP_HEADING: kh_ff     <= csr_data;
               default: ;
            endcase
         end
      end
      err_ff <= err_in; acc_ff <= acc_in; lin_ff <= lin_in; ang_ff <= ang_in;
      out_lin_ff <= out_lin_in; out_ang_ff <= out_ang_in; out_mode_ff <= out_mode_in;
      if (state_ff == S_IDLE && req_valid) begin
         an_ff <= req_ahead_narrow_min; aw_ff <= req_ahead_wide_min;
         lw_ff <= req_left_wide_min; lm_ff <= req_left_mid_min;
         ln_ff <= req_left_narrow_min; lb_ff <= req_left_broad_min;
         fl_ff <= req_front_left_min; fm_ff <= req_front_left_median;
         hd_ff <= req_wall_heading;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_linear_velocity = out_lin_ff;
   assign rsp_angular_velocity = out_ang_ff;
   assign rsp_mode_after = out_mode_ff;
endmodule

// ===== sv/wfmc_checker.sv =====
// wfmc_checker: port-level assertions for wall_follow_mode_controller_core.
// Depends on wfmc_pkg and the core's ports; bound to the top level below.
`timescale 1ns / 1ps
module wfmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_mode_after
);
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode_after <= wfmc_pkg::MODE_IDLE) else $error("bad mode");
   a_mode_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_mode_after)) else $error("word changed");
   a_accept_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("second accept");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
endmodule

bind wall_follow_mode_controller_core wfmc_checker u_wfmc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_mode_after(rsp_mode_after));
